/* sv/ota_pkg.sv */
// Shared types, register indexes and transform codes for the orientation
// transform address generator. No dependencies.
`timescale 1ns / 1ps

package ota_pkg;

  localparam int unsigned MAX_DIM_DEF = 4096;

  // Widths fixed by the register map and the stream fields
  localparam int unsigned DIM_W    = 13;
  localparam int unsigned EDGE_W   = 4;
  localparam int unsigned XF_W     = 3;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned CFG_DW   = 13;
  localparam int unsigned PIX_W    = 24;
  localparam int unsigned COORD_W  = 12;
  localparam int unsigned OFFS_W   = 26;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_EDGE_C = 3'd2;
  localparam logic [IDX_W-1:0] REG_EDGE_R = 3'd3;
  localparam logic [IDX_W-1:0] REG_XFORM  = 3'd4;
  localparam logic [IDX_W-1:0] REG_RGB    = 3'd5;

  // Transform codes
  localparam logic [XF_W-1:0] XF_NONE       = 3'd0;
  localparam logic [XF_W-1:0] XF_FLIP_H     = 3'd1;
  localparam logic [XF_W-1:0] XF_FLIP_V     = 3'd2;
  localparam logic [XF_W-1:0] XF_TRANSPOSE  = 3'd3;
  localparam logic [XF_W-1:0] XF_TRANSVERSE = 3'd4;
  localparam logic [XF_W-1:0] XF_ROT90      = 3'd5;
  localparam logic [XF_W-1:0] XF_ROT180     = 3'd6;
  localparam logic [XF_W-1:0] XF_ROT270     = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_start;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] dest_row;
    logic [COORD_W-1:0] dest_col;
    logic [OFFS_W-1:0]  dest_offset;
    logic [PIX_W-1:0]   pixel_out;
    logic               frame_last;
  } out_t;

  // Working configuration, dimensions already clamped to 1..cap
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [EDGE_W-1:0] edge_cols;
    logic [EDGE_W-1:0] edge_rows;
    logic [XF_W-1:0]   xform;
    logic              rgb;
  } cfg_t;

  // Source position and pixel held in the input stage
  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic [PIX_W-1:0] pixel;
  } pos_t;

endpackage

/* sv/ota_pos.sv */
// Input stage: source raster position counters and the input register.
// Depends on ota_pkg.
`timescale 1ns / 1ps

module ota_pos
  import ota_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic take,
  input  in_t  in_item,
  input  cfg_t cfg,
  output pos_t stage_q
);

  logic [DIM_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] cur_row, cur_col;
  logic [DIM_W:0]   row_inc, col_inc;
  logic             restart;
  pos_t             stage_r;

  always_comb begin
    // Restart on request, or when a register write left the position outside the frame
    restart = in_item.frame_start || (row_r >= cfg.height) || (col_r >= cfg.width);
    cur_row = restart ? '0 : row_r;
    cur_col = restart ? '0 : col_r;
    row_inc = {1'b0, cur_row} + 1'b1;
    col_inc = {1'b0, cur_col} + 1'b1;
    if (col_inc >= {1'b0, cfg.width}) begin
      col_nxt = '0;
      row_nxt = (row_inc >= {1'b0, cfg.height}) ? '0 : row_inc[DIM_W-1:0];
    end else begin
      col_nxt = col_inc[DIM_W-1:0];
      row_nxt = cur_row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (take) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      stage_r.row   <= cur_row;
      stage_r.col   <= cur_col;
      stage_r.pixel <= in_item.pixel_value;
    end
  end

  assign stage_q = stage_r;

endmodule

/* sv/ota_map.sv */
// Destination mapping: row/column remap per transform, edge handling and
// padded byte offset. Combinational. Depends on ota_pkg.
`timescale 1ns / 1ps

module ota_map
  import ota_pkg::*;
(
  input  cfg_t cfg,
  input  pos_t pos,
  output out_t result
);

  logic [DIM_W:0]   w, h, r, c, ex, ey;
  logic [DIM_W:0]   flip_c, flip_r, turn_c, turn_r, dr, dc;
  logic [DIM_W-1:0] dest_w;
  logic [DIM_W+1:0] line;
  logic [DIM_W+2:0] scan;
  logic [DIM_W+1:0] col_bytes;
  logic [28:0]      row_bytes;

  always_comb begin
    w  = {1'b0, cfg.width};
    h  = {1'b0, cfg.height};
    r  = {1'b0, pos.row};
    c  = {1'b0, pos.col};
    ex = (DIM_W+1)'(cfg.edge_cols);
    ey = (DIM_W+1)'(cfg.edge_rows);

    // Edge columns/rows stay put when mirroring
    flip_c = (c + ex < w) ? (w - ex - 1'b1 - c) : c;
    flip_r = (r >= ey) ? (h - 1'b1 + ey - r) : r;
    // Edge columns/rows wrap round when turning
    turn_c = (c + ex >= w) ? (w - 1'b1 - c) : (ex + c);
    turn_r = (r < ey) ? (h - 1'b1 - r) : (r - ey);

    dest_w = cfg.width;
    case (cfg.xform)
      XF_FLIP_H: begin
        dr = r;
        dc = flip_c;
      end
      XF_FLIP_V: begin
        dr = flip_r;
        dc = c;
      end
      XF_TRANSPOSE: begin
        dr = w - 1'b1 - c;
        dc = h - 1'b1 - r;
        dest_w = cfg.height;
      end
      XF_TRANSVERSE: begin
        dr = turn_c;
        dc = turn_r;
        dest_w = cfg.height;
      end
      XF_ROT90: begin
        dr = w - 1'b1 - c;
        dc = turn_r;
        dest_w = cfg.height;
      end
      XF_ROT180: begin
        dr = flip_r;
        dc = flip_c;
      end
      XF_ROT270: begin
        dr = turn_c;
        dc = h - 1'b1 - r;
        dest_w = cfg.height;
      end
      default: begin
        dr = r;
        dc = c;
      end
    endcase

    // Scan line padded up to a multiple of four bytes
    line = {2'b00, dest_w} + (cfg.rgb ? {1'b0, dest_w, 1'b0} : '0);
    scan = ({1'b0, line} + 3'd3) & ~(DIM_W+3)'(3);
    col_bytes = {2'b00, dc[DIM_W-1:0]} + (cfg.rgb ? {1'b0, dc[DIM_W-1:0], 1'b0} : '0);
    row_bytes = 29'(dr[DIM_W-1:0]) * 29'(scan);

    result.dest_row    = dr[COORD_W-1:0];
    result.dest_col    = dc[COORD_W-1:0];
    result.dest_offset = row_bytes[OFFS_W-1:0] + OFFS_W'(col_bytes);
    result.pixel_out   = pos.pixel;
    result.frame_last  = (r == h - 1'b1) && (c == w - 1'b1);
  end

endmodule

/* sv/orientation_transform_address_gen.sv */
// Orientation transform address generator: takes one pixel per clock in source
// raster order, unless the output stalls, and returns it with its destination
// row, column and byte offset. Throughput is one pixel per cycle while out_ready
// is held high. Each pixel passes through the input register and then the
// result register, around the mapping logic, whose longest path is the
// destination row times padded scan width multiply. Registers may be written
// only while no pixel is in flight. Depends on ota_pkg, ota_pos and ota_map.
`timescale 1ns / 1ps

module orientation_transform_address_gen
  import ota_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  localparam int unsigned      DimCap  = (MAX_DIM > 8191) ? 8191 : MAX_DIM;
  localparam logic [DIM_W-1:0] DIM_CAP = DIM_W'(DimCap);

  logic [DIM_W-1:0]  width_r, height_r;
  logic [EDGE_W-1:0] edge_c_r, edge_r_r;
  logic [XF_W-1:0]   xform_r;
  logic              rgb_r;
  cfg_t              cfg;

  logic s1_valid_r, s1_valid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic s2_adv, in_take;
  pos_t s1_pos;
  out_t mapped;
  out_t out_data_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_W'(1);
      height_r <= DIM_W'(1);
      edge_c_r <= '0;
      edge_r_r <= '0;
      xform_r  <= XF_NONE;
      rgb_r    <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  width_r  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: height_r <= cfg_data[DIM_W-1:0];
        REG_EDGE_C: edge_c_r <= cfg_data[EDGE_W-1:0];
        REG_EDGE_R: edge_r_r <= cfg_data[EDGE_W-1:0];
        REG_XFORM:  xform_r  <= cfg_data[XF_W-1:0];
        REG_RGB:    rgb_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width     = (width_r == '0) ? DIM_W'(1) : ((width_r > DIM_CAP) ? DIM_CAP : width_r);
    cfg.height    = (height_r == '0) ? DIM_W'(1) :
                    ((height_r > DIM_CAP) ? DIM_CAP : height_r);
    cfg.edge_cols = edge_c_r;
    cfg.edge_rows = edge_r_r;
    cfg.xform     = xform_r;
    cfg.rgb       = rgb_r;
  end

  // Result register frees up when empty or when its transfer completes
  assign s2_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_adv;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = in_take ? 1'b1 : (s2_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s2_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  ota_pos u_pos (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (in_take),
    .in_item (in_data),
    .cfg     (cfg),
    .stage_q (s1_pos)
  );

  ota_map u_map (
    .cfg    (cfg),
    .pos    (s1_pos),
    .result (mapped)
  );

  always_ff @(posedge clk) begin
    if (s2_adv && s1_valid_r) begin
      out_data_r <= mapped;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An empty result register never blocks the input
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  // A held input stage keeps its position
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_adv) |=> (s1_valid_r && $stable(s1_pos)))
    else $error("input stage lost or changed a held pixel");

  // Frame start places the pixel at the origin
  a_origin: assert property (@(posedge clk) disable iff (!rst_n)
    (in_take && in_data.frame_start) |=> (s1_pos.row == '0 && s1_pos.col == '0))
    else $error("frame start did not restart the position");

  // Stage moves into the result register whenever it is free
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s2_adv) |=> out_valid_r)
    else $error("pixel dropped between stages");

endmodule
